// File: sv/xoodoo_pkg.sv
// Shared types, constants and helpers for the Xoodoo permutation block.
// Used by xoodoo_round and xoodoo_permutation_top.
package xoodoo_pkg;

  localparam int unsigned LaneW     = 32;
  localparam int unsigned NumLanes  = 12;
  localparam int unsigned NumCols   = 4;
  localparam int unsigned MaxRounds = 12;
  localparam int unsigned RoundW    = 4;

  localparam int unsigned ThetaRotA = 5;
  localparam int unsigned ThetaRotB = 14;
  localparam int unsigned WestRot   = 11;
  localparam int unsigned EastRot1  = 1;
  localparam int unsigned EastRot2  = 8;

  typedef logic [LaneW-1:0]      lane_t;
  typedef lane_t [NumLanes-1:0]  state_t;
  typedef logic [RoundW-1:0]     round_t;

  localparam round_t RoundsReset = round_t'(MaxRounds);

  // Round constant by round index counted down to zero at the last round.
  localparam lane_t IotaRc [MaxRounds] = '{
    32'h0000_0012, 32'h0000_01A0, 32'h0000_00F0, 32'h0000_0380,
    32'h0000_002C, 32'h0000_0060, 32'h0000_0014, 32'h0000_0120,
    32'h0000_00D0, 32'h0000_03C0, 32'h0000_0038, 32'h0000_0058
  };

  function automatic lane_t rotl(lane_t v, int unsigned r);
    return (v << r) | (v >> (LaneW - r));
  endfunction

endpackage

// File: sv/xoodoo_round.sv
// One Xoodoo round: theta, rho-west, iota, chi, rho-east.
// Depends on xoodoo_pkg for lane types, rotations and the round constants.
module xoodoo_round (
  input  xoodoo_pkg::state_t state_i,
  input  xoodoo_pkg::round_t rnd_i,
  output xoodoo_pkg::state_t state_o
);

  xoodoo_pkg::lane_t  par [xoodoo_pkg::NumCols];
  xoodoo_pkg::lane_t  eff [xoodoo_pkg::NumCols];
  xoodoo_pkg::state_t th;
  xoodoo_pkg::state_t wst;
  xoodoo_pkg::state_t chi;

  always_comb begin
    for (int x = 0; x < 4; x++) begin
      par[x] = state_i[x] ^ state_i[4+x] ^ state_i[8+x];
    end
    for (int x = 0; x < 4; x++) begin
      eff[x] = xoodoo_pkg::rotl(par[(x+3)&3], xoodoo_pkg::ThetaRotA) ^
               xoodoo_pkg::rotl(par[(x+3)&3], xoodoo_pkg::ThetaRotB);
    end
    for (int y = 0; y < 3; y++) begin
      for (int x = 0; x < 4; x++) begin
        th[4*y+x] = state_i[4*y+x] ^ eff[x];
      end
    end
    for (int x = 0; x < 4; x++) begin
      wst[x]   = th[x];
      wst[4+x] = th[4+((x+3)&3)];
      wst[8+x] = xoodoo_pkg::rotl(th[8+x], xoodoo_pkg::WestRot);
    end
    wst[0] = wst[0] ^ xoodoo_pkg::IotaRc[rnd_i];
    for (int x = 0; x < 4; x++) begin
      chi[x]   = wst[x]   ^ (~wst[4+x] & wst[8+x]);
      chi[4+x] = wst[4+x] ^ (~wst[8+x] & wst[x]);
      chi[8+x] = wst[8+x] ^ (~wst[x]   & wst[4+x]);
    end
    for (int x = 0; x < 4; x++) begin
      state_o[x]   = chi[x];
      state_o[4+x] = xoodoo_pkg::rotl(chi[4+x], xoodoo_pkg::EastRot1);
      state_o[8+x] = xoodoo_pkg::rotl(chi[8+((x+2)&3)], xoodoo_pkg::EastRot2);
    end
  end

endmodule

// File: sv/xoodoo_permutation_top.sv
// Xoodoo 384-bit permutation engine, one round per clock on a state register.
// Depends on xoodoo_pkg and xoodoo_round.
//
// Usage:
//   Command channel: a state of twelve 32-bit lanes is taken at a rising edge
//   with start high and busy low. Lane index is 4*plane + column.
//   Result channel: done_o is high for one cycle while out_lane_*_o carry the
//   permuted state; the result transfers at the edge ending that cycle.
//   Round count: cfg_we_i writes cfg_wdata_i into the round count register
//   (reset 12); values above 12 run 12 rounds, zero passes the state through.
//   Write it only while the block is idle.
//   Rounds: with n effective rounds, busy stays high while one round unit
//   updates the state register once per round; done_o rises together with
//   the final state (with the loaded state when n is zero).
//   Back-to-back: no command is taken while busy; a new command may transfer in
//   the cycle done_o is high.
//   Reset: asynchronous, active low; clears busy, done_o and sets the round
//   count to 12. The receiver cannot stall, so no result is ever held back.
module xoodoo_permutation_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic [31:0] in_lane_0_i,
  input  logic [31:0] in_lane_1_i,
  input  logic [31:0] in_lane_2_i,
  input  logic [31:0] in_lane_3_i,
  input  logic [31:0] in_lane_4_i,
  input  logic [31:0] in_lane_5_i,
  input  logic [31:0] in_lane_6_i,
  input  logic [31:0] in_lane_7_i,
  input  logic [31:0] in_lane_8_i,
  input  logic [31:0] in_lane_9_i,
  input  logic [31:0] in_lane_10_i,
  input  logic [31:0] in_lane_11_i,
  output logic        done_o,
  output logic [31:0] out_lane_0_o,
  output logic [31:0] out_lane_1_o,
  output logic [31:0] out_lane_2_o,
  output logic [31:0] out_lane_3_o,
  output logic [31:0] out_lane_4_o,
  output logic [31:0] out_lane_5_o,
  output logic [31:0] out_lane_6_o,
  output logic [31:0] out_lane_7_o,
  output logic [31:0] out_lane_8_o,
  output logic [31:0] out_lane_9_o,
  output logic [31:0] out_lane_10_o,
  output logic [31:0] out_lane_11_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic                 st_q, st_d;
  logic                 done_q, done_d;
  xoodoo_pkg::round_t   rnd_q, rnd_d;
  xoodoo_pkg::round_t   nrounds_q;
  xoodoo_pkg::round_t   neff;
  xoodoo_pkg::state_t   lanes_q, lanes_d;
  xoodoo_pkg::state_t   in_state;
  xoodoo_pkg::state_t   rnd_out;
  logic                 accept;

  assign in_state = {in_lane_11_i, in_lane_10_i, in_lane_9_i, in_lane_8_i,
                     in_lane_7_i,  in_lane_6_i,  in_lane_5_i, in_lane_4_i,
                     in_lane_3_i,  in_lane_2_i,  in_lane_1_i, in_lane_0_i};

  assign accept = start && (st_q == StIdle);
  assign neff   = (nrounds_q > xoodoo_pkg::RoundsReset) ? xoodoo_pkg::RoundsReset
                                                        : nrounds_q;

  xoodoo_round u_round (
    .state_i (lanes_q),
    .rnd_i   (rnd_q),
    .state_o (rnd_out)
  );

  always_comb begin
    st_d    = st_q;
    done_d  = 1'b0;
    rnd_d   = rnd_q;
    lanes_d = lanes_q;
    unique case (st_q)
      StIdle: begin
        if (accept) begin
          lanes_d = in_state;
          if (neff == '0) begin
            done_d = 1'b1;
          end else begin
            rnd_d = neff - 1'b1;
            st_d  = StRun;
          end
        end
      end
      StRun: begin
        lanes_d = rnd_out;
        rnd_d   = rnd_q - 1'b1;
        if (rnd_q == '0) begin
          st_d   = StIdle;
          done_d = 1'b1;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StIdle;
      done_q    <= 1'b0;
      rnd_q     <= '0;
      nrounds_q <= xoodoo_pkg::RoundsReset;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
      rnd_q  <= rnd_d;
      if (cfg_we_i) begin
        nrounds_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lanes_q <= lanes_d;
  end

  assign busy          = (st_q == StRun);
  assign done_o        = done_q;
  assign out_lane_0_o  = lanes_q[0];
  assign out_lane_1_o  = lanes_q[1];
  assign out_lane_2_o  = lanes_q[2];
  assign out_lane_3_o  = lanes_q[3];
  assign out_lane_4_o  = lanes_q[4];
  assign out_lane_5_o  = lanes_q[5];
  assign out_lane_6_o  = lanes_q[6];
  assign out_lane_7_o  = lanes_q[7];
  assign out_lane_8_o  = lanes_q[8];
  assign out_lane_9_o  = lanes_q[9];
  assign out_lane_10_o = lanes_q[10];
  assign out_lane_11_o = lanes_q[11];

endmodule

// File: sv/xoodoo_chk.sv
// Port-level checks for xoodoo_permutation_top, attached by bind.
// Sees only the top level's handshake ports.
module xoodoo_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  // Accepted command either starts rounds or finishes at once.
  a_cmd_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || done_o)
    else $error("command transfer not followed by busy or done");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("done strobe while busy");

  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("rounds ended without result transfer");

  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy) || $past(start && !busy))
    else $error("result transfer without a command");

endmodule

bind xoodoo_permutation_top xoodoo_chk u_xoodoo_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o)
);
